FILE: rtl/bmf_pkg.sv
// Shared types and constants of the MP4 top-level box finder.
package bmf_pkg;

  // Result codes carried in the status field.
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One input beat: a file byte and the end-of-file flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    status_e     status;
    logic [31:0] box_offset;
    logic [31:0] box_size;
  } out_beat_t;

  // Classification the front attaches to each byte before it is queued.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       in_range;
  } byte_tag_t;

  localparam logic [31:0] TARGET_RESET = 32'h6D6F6F76;  // "moov"
  localparam logic [3:0]  HDR_BYTES    = 4'd8;
  localparam logic [31:0] HDR_SIZE_MIN = 32'd8;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic REG_TARGET_NAME = 1'b0;

endpackage

FILE: rtl/bmf_front.sv
// Front end: accept byte beats, track the saturating file position, tag each byte.
module bmf_front #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  bmf_pkg::in_beat_t           in_data_i,
  input  logic                        q_full_i,
  output logic                        in_stall_o,
  output logic                        push_o,
  output bmf_pkg::byte_tag_t          push_tag_o,
  output logic [OFFSET_BITS-1:0]      push_pos_o
);
  import bmf_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   in_range;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign in_range   = (pos_q != POS_MAX);

  always_comb begin
    push_tag_o.data_byte = in_data_i.data_byte;
    push_tag_o.last_byte = in_data_i.last_byte;
    push_tag_o.in_range  = in_range;
    push_pos_o           = pos_q;
  end

  // Advance the position per byte, hold it when saturated, clear at end of file.
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (in_data_i.last_byte) begin
        pos_d = '0;
      end else if (in_range) begin
        pos_d = pos_q + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: rtl/bmf_queue.sv
// Short queue between the front end and the box walker.
module bmf_queue #(
  parameter int unsigned WIDTH = 43
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);
  import bmf_pkg::*;

  logic [WIDTH-1:0]     mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q;

  assign full_o  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QPTR_BITS'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QPTR_BITS'(rd_ptr_q + 1'b1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= QCNT_BITS'(count_q + 1'b1);
        2'b01:   count_q <= QCNT_BITS'(count_q - 1'b1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/bmf_walker.sv
// Box walker: collect headers, check size and type, follow the chain, hold the result.
module bmf_walker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            target_i,
  input  logic                   q_valid_i,
  input  bmf_pkg::byte_tag_t     q_tag_i,
  input  logic [OFFSET_BITS-1:0] q_pos_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output bmf_pkg::out_beat_t     out_data_o,
  input  logic                   out_stall_i
);
  import bmf_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam int unsigned SUM_BITS = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;

  logic [OFFSET_BITS-1:0] nho_q, nho_d;
  logic [63:0]            shift_q, shift_d;
  logic [3:0]             cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic                   done_q, done_d;

  logic                   out_valid_q;
  out_beat_t              out_q;

  logic                   res_vld;
  out_beat_t              res;
  logic [31:0]            hdr_size;
  logic [31:0]            hdr_type;
  logic [SUM_BITS-1:0]    sum;
  logic                   sum_sat;

  // Take a byte only when the output slot is free or drains this cycle.
  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hdr_size = shift_q[63:32];
  assign hdr_type = shift_q[31:0];
  assign sum      = SUM_BITS'(nho_q) + SUM_BITS'(hdr_size);
  assign sum_sat  = |sum[SUM_BITS-1:OFFSET_BITS];

  always_comb begin
    nho_d   = nho_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    done_d  = done_q;
    res_vld = 1'b0;
    res     = '{status: ST_NOT_FOUND, box_offset: 32'd0, box_size: 32'd0};
    if (pop_o) begin
      if (!done_q && q_tag_i.in_range) begin
        if (pend_q) begin
          pend_d  = 1'b0;
          cnt_d   = '0;
          shift_d = '0;
          if (hdr_size < HDR_SIZE_MIN) begin
            res_vld = 1'b1;
            res     = '{status: ST_BAD_SIZE, box_offset: 32'(nho_q), box_size: hdr_size};
            done_d  = 1'b1;
          end else if (hdr_type == target_i) begin
            res_vld = 1'b1;
            res     = '{status: ST_FOUND, box_offset: 32'(nho_q), box_size: hdr_size};
            done_d  = 1'b1;
          end else if (sum_sat) begin
            nho_d = POS_MAX;
          end else begin
            nho_d = sum[OFFSET_BITS-1:0];
          end
        end
        // Shift in a header byte while collecting, or where a new header starts.
        if (!done_d && ((cnt_d != '0) || (q_pos_i == nho_d))) begin
          shift_d = {shift_d[55:0], q_tag_i.data_byte};
          cnt_d   = 4'(cnt_d + 4'd1);
          if (cnt_d >= HDR_BYTES) begin
            pend_d = 1'b1;
          end
        end
      end
      if (q_tag_i.last_byte) begin
        if (!done_d) begin
          res_vld = 1'b1;
          res     = '{status: ST_NOT_FOUND, box_offset: 32'd0, box_size: 32'd0};
        end
        nho_d   = '0;
        shift_d = '0;
        cnt_d   = '0;
        pend_d  = 1'b0;
        done_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nho_q       <= '0;
      shift_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      nho_q   <= nho_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (pop_o && res_vld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_vld) begin
      out_q <= res;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= HDR_BYTES)
    else $error("header byte count above header length");

  a_pend_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cnt_q == HDR_BYTES))
    else $error("pending check without a full header");

  a_eof_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_tag_i.last_byte) |=> (!done_q && !pend_q && (cnt_q == '0)
                                      && (nho_q == '0)))
    else $error("walk state not cleared after end of file");

  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_tag_i.last_byte && !done_q) |=> out_valid_q)
    else $error("end of file without a result");

endmodule

FILE: rtl/mp4_top_level_box_finder_unit.sv
// Top level of the MP4 top-level box finder: register port, front end, queue, walker.
//
// Usage: feed a file one byte per input beat on in_data_i, with last_byte set on
// the final byte. The block walks the chain of top-level boxes and gives exactly
// one output beat per file: found (offset and size of the first box whose type
// equals target_name), bad_size (a box size below 8), or not_found on the last
// byte when the chain runs off the end of the file.
// target_name sits at byte address 0 of the APB port; reset value is "moov".
// Write it only while no file is in flight.
// Throughput: one byte per cycle while the result channel is not stalled, bounded
// by the walker's single pass per byte (header shift, next-offset add and compare).
// The byte that causes a result passes the queue write and then the output register,
// where the result becomes valid.
// Reset clears the position, queue and walk state and restores target_name.
// When the receiver stalls, the result holds and the walker leaves the next byte
// at the queue head; the four-entry queue then fills and in_stall_o rises.
module mp4_top_level_box_finder_unit #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte channel
  input  logic                in_valid_i,
  input  bmf_pkg::in_beat_t   in_data_i,
  output logic                in_stall_o,
  // result channel
  output logic                out_valid_o,
  output bmf_pkg::out_beat_t  out_data_o,
  input  logic                out_stall_i,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bmf_pkg::*;

  localparam int unsigned ENTRY_BITS = $bits(byte_tag_t) + OFFSET_BITS;

  logic [31:0]            target_q;
  logic                   reg_sel;

  logic                   q_full;
  logic                   push;
  byte_tag_t              push_tag;
  logic [OFFSET_BITS-1:0] push_pos;
  logic                   pop;
  logic                   q_valid;
  logic [ENTRY_BITS-1:0]  q_head;
  byte_tag_t              head_tag;
  logic [OFFSET_BITS-1:0] head_pos;

  // Register port: one 32-bit register, no wait states.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TARGET_NAME);
  assign prdata  = reg_sel ? target_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      target_q <= pwdata;
    end
  end

  // Front end: accept beats and tag them with position and range.
  bmf_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .push_tag_o (push_tag),
    .push_pos_o (push_pos)
  );

  // Queue: decouple the front end from a stalled walker.
  bmf_queue #(
    .WIDTH(ENTRY_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_tag, push_pos}),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  assign head_tag = byte_tag_t'(q_head[ENTRY_BITS-1:OFFSET_BITS]);
  assign head_pos = q_head[OFFSET_BITS-1:0];

  // Walker: follow the box chain and drive the result channel.
  bmf_walker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .target_i    (target_q),
    .q_valid_i   (q_valid),
    .q_tag_i     (head_tag),
    .q_pos_i     (head_pos),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
